@@ rtl/fvac_pkg.sv @@
`timescale 1ns / 1ps
package fvac_pkg;

	localparam int PRICE_W    = 32;
	localparam int VOL_W      = 32;
	localparam int HIST_DEPTH = 256;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = HIST_AW + 1;
	localparam int SEEN_W     = 9;
	localparam logic [SEEN_W-1:0] SEEN_MAX = 9'd511;
	localparam int FRAC_W     = 8;
	localparam int FACT_W     = 16;
	localparam int PRD_W      = 64;
	localparam int PSUM_W     = PRICE_W + VOL_W + HIST_AW;
	localparam int VSUM_W     = VOL_W + HIST_AW;
	localparam int TRSUM_W    = PRICE_W + HIST_AW;
	localparam int DNUM_W     = PSUM_W + FRAC_W;
	localparam int DDEN_W     = VSUM_W;
	localparam int DQ_W       = PRICE_W + FRAC_W;
	localparam int DCNT_W     = $clog2(DNUM_W + 1);
	localparam int TOL_W      = PRICE_W + FACT_W;
	localparam int GAP_W      = 32;
	localparam int VWAP_W     = 40;
	localparam int SCORE_W    = 2;
	localparam int IN_W       = 128;
	localparam int OUT_PAD_W  = 6;
	localparam int OUT_W      = OUT_PAD_W + VWAP_W + GAP_W + SCORE_W;
	localparam int CFG_AW     = 4;
	localparam int CFG_DW     = 32;

	localparam logic [1:0] REG_VWAP_PERIOD = 2'd0;
	localparam logic [1:0] REG_ATR_LENGTH  = 2'd1;
	localparam logic [1:0] REG_TOL_FACTOR  = 2'd2;

	localparam logic [7:0]        VWAP_PERIOD_RST = 8'd60;
	localparam logic [7:0]        ATR_LENGTH_RST  = 8'd14;
	localparam logic [FACT_W-1:0] TOL_FACTOR_RST  = 16'd128;

	// divide by three: floor(x/3) = (x * RECIP3) >> RECIP3_SH for 32-bit x
	localparam logic [PRICE_W-1:0] RECIP3     = 32'hAAAA_AAAB;
	localparam int                 RECIP3_SH  = PRICE_W + 1;
	localparam logic [PRICE_W-1:0] THIRD_WORD = 32'h5555_5555;
	localparam logic [FRAC_W-1:0]  THIRD_FRAC = 8'd85;

	typedef struct packed {
		logic [VOL_W-1:0]   volume;
		logic [PRICE_W-1:0] close;
		logic [PRICE_W-1:0] low;
		logic [PRICE_W-1:0] high;
	} bar_t;

	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [VWAP_W-1:0]    vwap;
		logic [GAP_W-1:0]     gap;
		logic [SCORE_W-1:0]   score;
	} res_t;

	typedef struct packed {
		logic [7:0]        vwap_period;
		logic [7:0]        atr_length;
		logic [FACT_W-1:0] tol_factor;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_VSTART,
		ST_VWAIT,
		ST_ASTART,
		ST_AWAIT,
		ST_PSTART,
		ST_PWAIT,
		ST_TOL1,
		ST_TOL2,
		ST_TOL3,
		ST_SCORE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic rd_walk;
		logic div_go;
		logic out_load;
	} ctl_t;

endpackage

@@ rtl/fvac_hist.sv @@
`timescale 1ns / 1ps
module fvac_hist (
	input  logic                        clk,
	input  logic                        we,
	input  logic [fvac_pkg::HIST_AW-1:0] waddr,
	input  fvac_pkg::bar_t              wdata,
	input  logic [fvac_pkg::HIST_AW-1:0] raddr,
	output fvac_pkg::bar_t              rdata
);

	fvac_pkg::bar_t mem [fvac_pkg::HIST_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/fvac_div.sv @@
`timescale 1ns / 1ps
module fvac_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [fvac_pkg::DNUM_W-1:0]  num,
	input  logic [fvac_pkg::DDEN_W-1:0]  den,
	output logic [fvac_pkg::DQ_W-1:0]    quo,
	output logic                         done
);

	logic                        busy_q;
	logic                        done_q;
	logic [fvac_pkg::DCNT_W-1:0] cnt_q;
	logic [fvac_pkg::DNUM_W-1:0] num_q;
	logic [fvac_pkg::DDEN_W-1:0] den_q;
	logic [fvac_pkg::DDEN_W-1:0] rem_q;
	logic [fvac_pkg::DQ_W-1:0]   quo_q;
	logic [fvac_pkg::DDEN_W:0]   trial;
	logic [fvac_pkg::DDEN_W:0]   diff;
	logic                        ge;

	assign trial = {rem_q, num_q[fvac_pkg::DNUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fvac_pkg::DCNT_W'(fvac_pkg::DNUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[fvac_pkg::DNUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[fvac_pkg::DDEN_W-1:0] : trial[fvac_pkg::DDEN_W-1:0];
			quo_q <= {quo_q[fvac_pkg::DQ_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !busy_q) else $error("divider restarted while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("divider done without a run");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < fvac_pkg::DCNT_W'(fvac_pkg::DNUM_W)) else $error("divider overran");

endmodule

@@ rtl/fvac_cfg.sv @@
`timescale 1ns / 1ps
module fvac_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fvac_pkg::CFG_AW-1:0]  paddr,
	input  logic [fvac_pkg::CFG_DW-1:0]  pwdata,
	output logic [fvac_pkg::CFG_DW-1:0]  prdata,
	output fvac_pkg::cfg_t               cfg
);

	fvac_pkg::cfg_t cfg_q;
	logic           wr;
	logic [1:0]     idx;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vwap_period <= fvac_pkg::VWAP_PERIOD_RST;
			cfg_q.atr_length  <= fvac_pkg::ATR_LENGTH_RST;
			cfg_q.tol_factor  <= fvac_pkg::TOL_FACTOR_RST;
		end else if (wr) begin
			unique case (idx)
				fvac_pkg::REG_VWAP_PERIOD: cfg_q.vwap_period <= pwdata[7:0];
				fvac_pkg::REG_ATR_LENGTH:  cfg_q.atr_length  <= pwdata[7:0];
				fvac_pkg::REG_TOL_FACTOR:  cfg_q.tol_factor  <= pwdata[fvac_pkg::FACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fvac_pkg::REG_VWAP_PERIOD: prdata = {24'd0, cfg_q.vwap_period};
			fvac_pkg::REG_ATR_LENGTH:  prdata = {24'd0, cfg_q.atr_length};
			fvac_pkg::REG_TOL_FACTOR:  prdata = {16'd0, cfg_q.tol_factor};
			default:                   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/fvg_vwap_atr_confluence_core.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: high, low, close, volume (32b each)
// m_       out  m_tvalid/m_tready  m_tdata: score, gap, vwap, zero pad
// apb      cfg  psel/penable       vwap_period @0, atr_length @4, tol_factor @8
// One request at a time: a bar reads L history entries, L = longer window
// (3..256 entries), one history read per cycle, then two passes of the
// shared bit-serial divider (VWAP pass skipped on zero window volume), a
// reciprocal multiply for the pivot third and a few multiply/compare steps.
// First two bars: stored only. Reset clears control state only.
// A finished result waits in the output register; the next bar is taken meanwhile.
module fvg_vwap_atr_confluence_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fvac_pkg::IN_W-1:0]     s_tdata,   // high, low, close, volume
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fvac_pkg::OUT_W-1:0]    m_tdata,   // score[1:0], gap, vwap, pad
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fvac_pkg::CFG_AW-1:0]   paddr,
	input  logic [fvac_pkg::CFG_DW-1:0]   pwdata,
	output logic [fvac_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready
);

	fvac_pkg::state_t state_q, state_d;
	fvac_pkg::ctl_t   ctl;
	fvac_pkg::cfg_t   cfg;
	fvac_pkg::bar_t   in_q, rdata;
	fvac_pkg::res_t   out_q;
	logic             out_valid_q;
	logic             in_acc;

	logic [fvac_pkg::HIST_AW-1:0] wp_q, cur_q, rd_addr;
	logic [fvac_pkg::SEEN_W-1:0]  seen_q;
	logic [fvac_pkg::CNT_W-1:0]   nv_q, len_q, j_q, j_s1;
	logic [fvac_pkg::HIST_AW-1:0] na_q;
	logic [fvac_pkg::CNT_W-1:0]   nv_d, na_d, len_d, na1;
	logic                         v_s1, pv_s2, tv_s2;

	logic [fvac_pkg::PRD_W-1:0]   prod_s2;
	logic [fvac_pkg::VOL_W-1:0]   vol_s2;
	logic [fvac_pkg::PRICE_W-1:0] tr_s2, tr_d, d_hc, d_lc, d_hl, tr_a;
	logic [fvac_pkg::PRICE_W-1:0] hprev_q, lprev_q, h1_q, l1_q, c1_q, h2_q, l2_q;
	logic [fvac_pkg::PSUM_W-1:0]  psum_q;
	logic [fvac_pkg::VSUM_W-1:0]  vsum_q;
	logic [fvac_pkg::TRSUM_W-1:0] trsum_q;

	logic [fvac_pkg::PRICE_W-1:0] mul_a, mul_b;
	logic [fvac_pkg::DNUM_W-1:0]  div_num;
	logic [fvac_pkg::DDEN_W-1:0]  div_den;
	logic [fvac_pkg::DQ_W-1:0]    div_q;
	logic                         div_done;

	logic [fvac_pkg::DQ_W-1:0]    vwap_q, atr_q, piv_q;
	logic [fvac_pkg::TOL_W-1:0]   tol_q;
	logic [fvac_pkg::GAP_W-1:0]   gap_q, gap_d;
	logic [fvac_pkg::SCORE_W-1:0] score_q;
	logic [fvac_pkg::DQ_W-1:0]    mid, dvm, dvp, dmp;
	logic [fvac_pkg::PRICE_W+1:0] piv_sum;
	logic [fvac_pkg::PRICE_W-1:0] p3_ql, p3_rl, p3_hx, p3_q;
	logic [2:0]                   p3_t;
	logic [1:0]                   p3_r;
	logic                         p3_ge;
	logic [fvac_pkg::DQ_W-1:0]    piv_d;

	fvac_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	fvac_hist u_hist (
		.clk(clk), .we(in_acc), .waddr(wp_q), .wdata(fvac_pkg::bar_t'(s_tdata)),
		.raddr(rd_addr), .rdata(rdata)
	);

	fvac_div u_div (
		.clk(clk), .arst_n(arst_n), .go(ctl.div_go), .num(div_num), .den(div_den),
		.quo(div_q), .done(div_done)
	);

	assign pready   = 1'b1;
	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = ctl.in_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign rd_addr  = cur_q - j_q[fvac_pkg::HIST_AW-1:0];

	// window lengths
	always_comb begin
		nv_d = fvac_pkg::CNT_W'(cfg.vwap_period) + 1'b1;
		if (fvac_pkg::SEEN_W'(nv_d) > seen_q) nv_d = fvac_pkg::CNT_W'(seen_q);
		na_d = fvac_pkg::CNT_W'(cfg.atr_length) + 1'b1;
		if (fvac_pkg::SEEN_W'(na_d) > seen_q - 1'b1) na_d = fvac_pkg::CNT_W'(seen_q - 1'b1);
		if (na_d > fvac_pkg::CNT_W'(fvac_pkg::HIST_DEPTH - 1))
			na_d = fvac_pkg::CNT_W'(fvac_pkg::HIST_DEPTH - 1);
		len_d = nv_d;
		if (na_d + 1'b1 > len_d) len_d = na_d + 1'b1;
		if (len_d < fvac_pkg::CNT_W'(3)) len_d = fvac_pkg::CNT_W'(3);
	end

	assign na1 = fvac_pkg::CNT_W'(na_q);

	// true range of entry j-1 against close of entry j
	always_comb begin
		d_hc = (hprev_q >= rdata.close) ? hprev_q - rdata.close : rdata.close - hprev_q;
		d_lc = (lprev_q >= rdata.close) ? lprev_q - rdata.close : rdata.close - lprev_q;
		d_hl = hprev_q - lprev_q;
		tr_a = (d_lc > d_hc) ? d_lc : d_hc;
		tr_d = (hprev_q > lprev_q && d_hl > tr_a) ? d_hl : tr_a;
	end

	always_comb begin
		priority case (state_q)
			fvac_pkg::ST_PSTART: begin
				mul_a = piv_sum[fvac_pkg::PRICE_W-1:0];
				mul_b = fvac_pkg::RECIP3;
			end
			fvac_pkg::ST_TOL1: begin
				mul_a = fvac_pkg::PRICE_W'(cfg.tol_factor);
				mul_b = atr_q[fvac_pkg::DQ_W-1:fvac_pkg::FRAC_W];
			end
			fvac_pkg::ST_TOL2: begin
				mul_a = fvac_pkg::PRICE_W'(cfg.tol_factor);
				mul_b = fvac_pkg::PRICE_W'(atr_q[fvac_pkg::FRAC_W-1:0]);
			end
			default: begin
				mul_a = rdata.close;
				mul_b = rdata.volume;
			end
		endcase
	end

	always_comb begin
		priority case (state_q)
			fvac_pkg::ST_ASTART, fvac_pkg::ST_AWAIT: begin
				div_num = fvac_pkg::DNUM_W'({trsum_q, {fvac_pkg::FRAC_W{1'b0}}});
				div_den = fvac_pkg::DDEN_W'(na_q);
			end
			default: begin
				div_num = {psum_q, {fvac_pkg::FRAC_W{1'b0}}};
				div_den = vsum_q;
			end
		endcase
	end

	// pivot = (H+L+C)*256/3: low word through the reciprocal, 2^32 = 1 mod 3 folds the rest
	always_comb begin
		piv_sum = {2'b0, h1_q} + {2'b0, l1_q} + {2'b0, c1_q};
		p3_ql = fvac_pkg::PRICE_W'(prod_s2[fvac_pkg::PRD_W-1:fvac_pkg::RECIP3_SH]);
		p3_rl = piv_sum[fvac_pkg::PRICE_W-1:0] - ((p3_ql << 1) + p3_ql);
		p3_hx = fvac_pkg::PRICE_W'(piv_sum[fvac_pkg::PRICE_W+1:fvac_pkg::PRICE_W]) *
			fvac_pkg::THIRD_WORD;
		p3_t  = {1'b0, piv_sum[fvac_pkg::PRICE_W+1:fvac_pkg::PRICE_W]} + {1'b0, p3_rl[1:0]};
		p3_ge = (p3_t >= 3'd3);
		p3_q  = p3_hx + p3_ql + fvac_pkg::PRICE_W'(p3_ge);
		p3_r  = p3_ge ? 2'(p3_t - 3'd3) : p3_t[1:0];
		piv_d = {p3_q, fvac_pkg::FRAC_W'(p3_r * fvac_pkg::THIRD_FRAC)};
	end

	always_comb begin
		if (in_q.low > h2_q)      gap_d = in_q.low - h2_q;
		else if (l2_q > in_q.high) gap_d = l2_q - in_q.high;
		else                      gap_d = '0;
		mid = fvac_pkg::DQ_W'({1'b0, in_q.high} + {1'b0, in_q.low}) << (fvac_pkg::FRAC_W - 1);
		dvm = (vwap_q >= mid)   ? vwap_q - mid   : mid - vwap_q;
		dvp = (vwap_q >= piv_q) ? vwap_q - piv_q : piv_q - vwap_q;
		dmp = (mid >= piv_q)    ? mid - piv_q    : piv_q - mid;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fvac_pkg::ST_IDLE:   if (in_acc) state_d = fvac_pkg::ST_SETUP;
			fvac_pkg::ST_SETUP:  state_d = (seen_q < fvac_pkg::SEEN_W'(3)) ?
				fvac_pkg::ST_IDLE : fvac_pkg::ST_WALK;
			fvac_pkg::ST_WALK:   if (j_q == len_q - 1'b1) state_d = fvac_pkg::ST_DRAIN;
			fvac_pkg::ST_DRAIN:  if (!v_s1 && !pv_s2 && !tv_s2) state_d = fvac_pkg::ST_VSTART;
			fvac_pkg::ST_VSTART: state_d = (vsum_q == '0) ? fvac_pkg::ST_ASTART : fvac_pkg::ST_VWAIT;
			fvac_pkg::ST_VWAIT:  if (div_done) state_d = fvac_pkg::ST_ASTART;
			fvac_pkg::ST_ASTART: state_d = fvac_pkg::ST_AWAIT;
			fvac_pkg::ST_AWAIT:  if (div_done) state_d = fvac_pkg::ST_PSTART;
			fvac_pkg::ST_PSTART: state_d = fvac_pkg::ST_PWAIT;
			fvac_pkg::ST_PWAIT:  state_d = fvac_pkg::ST_TOL1;
			fvac_pkg::ST_TOL1:   state_d = fvac_pkg::ST_TOL2;
			fvac_pkg::ST_TOL2:   state_d = fvac_pkg::ST_TOL3;
			fvac_pkg::ST_TOL3:   state_d = fvac_pkg::ST_SCORE;
			fvac_pkg::ST_SCORE:  state_d = fvac_pkg::ST_OUT;
			fvac_pkg::ST_OUT:    if (!out_valid_q || m_tready) state_d = fvac_pkg::ST_IDLE;
			default:             state_d = fvac_pkg::ST_IDLE;
		endcase
	end

	// controls
	always_comb begin
		ctl = '0;
		unique case (state_q)
			fvac_pkg::ST_IDLE:   ctl.in_ready = 1'b1;
			fvac_pkg::ST_WALK:   ctl.rd_walk  = 1'b1;
			fvac_pkg::ST_VSTART: ctl.div_go   = (vsum_q != '0);
			fvac_pkg::ST_ASTART: ctl.div_go   = 1'b1;
			fvac_pkg::ST_OUT:    ctl.out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fvac_pkg::ST_IDLE;
			wp_q        <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			pv_s2       <= 1'b0;
			tv_s2       <= 1'b0;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				wp_q <= wp_q + 1'b1;
				if (seen_q != fvac_pkg::SEEN_MAX) seen_q <= seen_q + 1'b1;
			end
			if (ctl.out_load)               out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready)  out_valid_q <= 1'b0;
			v_s1  <= ctl.rd_walk;
			pv_s2 <= v_s1 && (j_s1 < nv_q);
			tv_s2 <= v_s1 && (j_s1 != '0) && (j_s1 <= na1);
			if (state_q == fvac_pkg::ST_SETUP) j_q <= '0;
			else if (ctl.rd_walk)              j_q <= j_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q  <= fvac_pkg::bar_t'(s_tdata);
			cur_q <= wp_q;
		end
		if (state_q == fvac_pkg::ST_SETUP) begin
			nv_q    <= nv_d;
			na_q    <= na_d[fvac_pkg::HIST_AW-1:0];
			len_q   <= len_d;
			psum_q  <= '0;
			vsum_q  <= '0;
			trsum_q <= '0;
		end else begin
			if (pv_s2) begin
				psum_q <= psum_q + fvac_pkg::PSUM_W'(prod_s2);
				vsum_q <= vsum_q + fvac_pkg::VSUM_W'(vol_s2);
			end
			if (tv_s2) trsum_q <= trsum_q + fvac_pkg::TRSUM_W'(tr_s2);
		end
		j_s1    <= j_q;
		prod_s2 <= fvac_pkg::PRD_W'(mul_a) * fvac_pkg::PRD_W'(mul_b);
		vol_s2  <= rdata.volume;
		tr_s2   <= tr_d;
		if (v_s1) begin
			hprev_q <= rdata.high;
			lprev_q <= rdata.low;
			if (j_s1 == fvac_pkg::CNT_W'(1)) begin
				h1_q <= rdata.high;
				l1_q <= rdata.low;
				c1_q <= rdata.close;
			end
			if (j_s1 == fvac_pkg::CNT_W'(2)) begin
				h2_q <= rdata.high;
				l2_q <= rdata.low;
			end
		end
		if (state_q == fvac_pkg::ST_VSTART && vsum_q == '0)
			vwap_q <= fvac_pkg::DQ_W'({in_q.close, {fvac_pkg::FRAC_W{1'b0}}});
		if (state_q == fvac_pkg::ST_VWAIT && div_done) vwap_q <= div_q;
		if (state_q == fvac_pkg::ST_AWAIT && div_done) atr_q  <= div_q;
		if (state_q == fvac_pkg::ST_PWAIT) piv_q <= piv_d;
		if (state_q == fvac_pkg::ST_TOL1) gap_q <= gap_d;
		if (state_q == fvac_pkg::ST_TOL2) tol_q <= prod_s2[fvac_pkg::TOL_W-1:0];
		if (state_q == fvac_pkg::ST_TOL3)
			tol_q <= tol_q + fvac_pkg::TOL_W'(prod_s2[fvac_pkg::FACT_W+fvac_pkg::FRAC_W-1:
				fvac_pkg::FRAC_W]);
		if (state_q == fvac_pkg::ST_SCORE) begin
			if (gap_q != '0)
				score_q <= fvac_pkg::SCORE_W'(
					{1'b0, fvac_pkg::TOL_W'(dvm) <= tol_q} +
					{1'b0, fvac_pkg::TOL_W'(dvp) <= tol_q} +
					{1'b0, fvac_pkg::TOL_W'(dmp) <= tol_q});
			else
				score_q <= '0;
		end
		if (ctl.out_load) begin
			out_q.pad   <= '0;
			out_q.vwap  <= vwap_q;
			out_q.gap   <= gap_q;
			out_q.score <= score_q;
		end
	end

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fvac_pkg::ST_DRAIN && state_d != fvac_pkg::ST_DRAIN)
		|-> !v_s1 && !pv_s2 && !tv_s2) else $error("walk left with reads in flight");
	a_atr_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fvac_pkg::ST_ASTART) |-> na_q != '0) else $error("zero true range count");
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> wp_q == $past(wp_q) + 1'b1) else $error("ring pointer slip");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !ctl.out_load) else $error("result overwritten");

endmodule

@@ verif/fvg_vwap_atr_confluence_core_tb.sv @@
`timescale 1ns / 1ps
module fvg_vwap_atr_confluence_core_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [fvac_pkg::IN_W-1:0]     s_tdata = '0;   // high, low, close, volume
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [fvac_pkg::OUT_W-1:0]    m_tdata;        // score[1:0], gap, vwap, pad
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [fvac_pkg::CFG_AW-1:0]   paddr = '0;
	logic [fvac_pkg::CFG_DW-1:0]   pwdata = '0;
	logic [fvac_pkg::CFG_DW-1:0]   prdata;
	logic                          pready;

	fvg_vwap_atr_confluence_core u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] hist_hi [fvac_pkg::HIST_DEPTH];
	logic [31:0] hist_lo [fvac_pkg::HIST_DEPTH];
	logic [31:0] hist_cl [fvac_pkg::HIST_DEPTH];
	logic [31:0] hist_vol [fvac_pkg::HIST_DEPTH];
	int          wr_ptr = 0;
	int          n_bars = 0;
	logic [7:0]  cur_vwap_period = fvac_pkg::VWAP_PERIOD_RST;
	logic [7:0]  cur_atr_length = fvac_pkg::ATR_LENGTH_RST;
	logic [15:0] cur_tol_factor = fvac_pkg::TOL_FACTOR_RST;

	fvac_pkg::res_t expected_results[$];
	int             n_errors = 0;
	int             idle_cycles = 0;
	bit             want_stall = 1'b0;

	function automatic int ring(int back);
		return (wr_ptr + 2 * fvac_pkg::HIST_DEPTH - 1 - back) % fvac_pkg::HIST_DEPTH;
	endfunction

	function automatic logic [63:0] adiff(logic [63:0] a, logic [63:0] b);
		return a >= b ? a - b : b - a;
	endfunction

	// returns 1 and fills res when the bar yields a result
	function automatic bit score_bar(fvac_pkg::bar_t b, output fvac_pkg::res_t res);
		int n, s, sp;
		logic [63:0] gap, vsum, trsum, atr, tol, tr, mid, piv, hk, lk, cp, vwap;
		logic [127:0] psum;
		logic [1:0] sc;
		hist_hi[wr_ptr] = b.high;
		hist_lo[wr_ptr] = b.low;
		hist_cl[wr_ptr] = b.close;
		hist_vol[wr_ptr] = b.volume;
		wr_ptr = (wr_ptr + 1) % fvac_pkg::HIST_DEPTH;
		if (n_bars < 511) n_bars++;
		res = '0;
		if (n_bars < 3) return 1'b0;
		gap = 0;
		if (hist_lo[ring(0)] > hist_hi[ring(2)])
			gap = hist_lo[ring(0)] - hist_hi[ring(2)];
		else if (hist_lo[ring(2)] > hist_hi[ring(0)])
			gap = hist_lo[ring(2)] - hist_hi[ring(0)];
		n = cur_vwap_period + 1;
		if (n > n_bars) n = n_bars;
		if (n > fvac_pkg::HIST_DEPTH) n = fvac_pkg::HIST_DEPTH;
		psum = 0;
		vsum = 0;
		for (int k = 0; k < n; k++) begin
			s = ring(k);
			psum += 128'(hist_cl[s]) * 128'(hist_vol[s]);
			vsum += hist_vol[s];
		end
		if (vsum != 0) vwap = 64'((psum << 8) / 128'(vsum));
		else vwap = 64'(hist_cl[ring(0)]) << 8;
		n = cur_atr_length + 1;
		if (n > n_bars - 1) n = n_bars - 1;
		if (n > fvac_pkg::HIST_DEPTH - 1) n = fvac_pkg::HIST_DEPTH - 1;
		trsum = 0;
		for (int k = 0; k < n; k++) begin
			s = ring(k);
			sp = ring(k + 1);
			hk = hist_hi[s];
			lk = hist_lo[s];
			cp = hist_cl[sp];
			tr = adiff(hk, cp);
			if (adiff(lk, cp) > tr) tr = adiff(lk, cp);
			if (hk > lk && hk - lk > tr) tr = hk - lk;
			trsum += tr;
		end
		atr = (trsum << 8) / 64'(n);
		tol = 64'(cur_tol_factor) * (atr >> 8) + ((64'(cur_tol_factor) * atr[7:0]) >> 8);
		mid = (64'(hist_hi[ring(0)]) + 64'(hist_lo[ring(0)])) << 7;
		piv = ((64'(hist_hi[ring(1)]) + hist_lo[ring(1)] + hist_cl[ring(1)]) << 8) / 3;
		sc = 0;
		if (gap != 0) begin
			if (adiff(vwap, mid) <= tol) sc++;
			if (adiff(vwap, piv) <= tol) sc++;
			if (adiff(mid, piv) <= tol) sc++;
		end
		res.score = sc;
		res.gap = gap[31:0];
		res.vwap = vwap[39:0];
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// a zero gap keeps tvalid up so the next request follows at once
	task automatic random_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// result side
	always @(posedge clk) begin
		fvac_pkg::res_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(got), 0);
			end else begin
				want = expected_results.pop_front();
				if (got.score !== want.score) report_mismatch("score", got.score, want.score);
				if (got.gap !== want.gap) report_mismatch("gap", got.gap, want.gap);
				if (got.vwap !== want.vwap) report_mismatch("vwap", got.vwap, want.vwap);
			end
		end
		m_tready <= want_stall ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) if ($urandom_range(0, 63) == 0) want_stall <= ~want_stall;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= fvac_pkg::CFG_AW'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			fvac_pkg::REG_VWAP_PERIOD: cur_vwap_period = val[7:0];
			fvac_pkg::REG_ATR_LENGTH:  cur_atr_length = val[7:0];
			default:                   cur_tol_factor = val[15:0];
		endcase
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic send_bar(fvac_pkg::bar_t b, bit chk, fvac_pkg::res_t fixed);
		fvac_pkg::res_t r;
		s_tdata <= b;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (score_bar(b, r)) begin
			if (chk && r !== fixed) report_mismatch("table row", 64'(r), 64'(fixed));
			expected_results.push_back(r);
		end
		random_gap();
	endtask

	function automatic logic [31:0] rand_price(logic [31:0] base, int spread);
		logic [31:0] p;
		case ($urandom_range(0, 7))
			0: p = $urandom;
			1: p = 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: p = $urandom_range(0, 3);
			default: p = base + $urandom_range(0, spread) - spread / 2;
		endcase
		return p;
	endfunction

	typedef struct {
		fvac_pkg::bar_t b;
		bit             chk;
		fvac_pkg::res_t want;
	} row_t;

	row_t dir_rows[$];

	initial begin
		fvac_pkg::bar_t b;
		logic [31:0] base, hh, ll;
		fvac_pkg::res_t none;
		none = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: zero bars give zero vwap and gap; extremes otherwise predicted
		dir_rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
		dir_rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
		dir_rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, none});
		dir_rows.push_back('{'{32'd5, 32'd100, 32'd200, 32'd300}, 1'b0, none});
		dir_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			1'b0, none});
		dir_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			1'b0, none});
		dir_rows.push_back('{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, none});
		dir_rows.push_back('{'{32'd1000, 32'd900, 32'd950, 32'd0}, 1'b0, none});
		dir_rows.push_back('{'{32'd1000, 32'd990, 32'd995, 32'd10}, 1'b0, none});
		dir_rows.push_back('{'{32'd1200, 32'd1100, 32'd1150, 32'd10}, 1'b0, none});
		dir_rows.push_back('{'{32'd800, 32'd700, 32'd750, 32'd10}, 1'b0, none});
		dir_rows.push_back('{'{32'd100, 32'd200, 32'd50, 32'd7}, 1'b0, none});
		dir_rows.push_back('{'{32'd102, 32'd101, 32'd101, 32'd7}, 1'b0, none});
		dir_rows.push_back('{'{32'd103, 32'd102, 32'd102, 32'd7}, 1'b0, none});
		dir_rows.push_back('{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
			1'b0, none});
		dir_rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
			1'b0, none});
		foreach (dir_rows[i]) send_bar(dir_rows[i].b, dir_rows[i].chk, dir_rows[i].want);
		wait_idle();

		// random phases across register settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					cfg_write(fvac_pkg::REG_VWAP_PERIOD, 32'd0);
					cfg_write(fvac_pkg::REG_ATR_LENGTH, 32'd0);
					cfg_write(fvac_pkg::REG_TOL_FACTOR, 32'd0);
				end
				1: begin
					cfg_write(fvac_pkg::REG_VWAP_PERIOD, 32'd255);
					cfg_write(fvac_pkg::REG_ATR_LENGTH, 32'd255);
					cfg_write(fvac_pkg::REG_TOL_FACTOR, 32'hFFFF);
				end
				2: begin
					cfg_write(fvac_pkg::REG_VWAP_PERIOD, 32'd2);
					cfg_write(fvac_pkg::REG_ATR_LENGTH, 32'd254);
					cfg_write(fvac_pkg::REG_TOL_FACTOR, 32'h0100);
				end
				default: begin
					cfg_write(fvac_pkg::REG_VWAP_PERIOD, $urandom_range(0, 40));
					cfg_write(fvac_pkg::REG_ATR_LENGTH, $urandom_range(0, 40));
					cfg_write(fvac_pkg::REG_TOL_FACTOR, $urandom);
				end
			endcase
			base = $urandom;
			for (int i = 0; i < 100; i++) begin
				base = base + $urandom_range(0, 2000) - 1000;
				hh = rand_price(base, 400);
				ll = ($urandom_range(0, 9) == 0) ? rand_price(base, 400)
					: hh - $urandom_range(0, 200);
				b.high = hh;
				b.low = ll;
				b.close = ($urandom_range(0, 4) == 0) ? $urandom : ll + $urandom_range(0, 200);
				case ($urandom_range(0, 5))
					0: b.volume = 0;
					1: b.volume = $urandom;
					2: b.volume = 32'hFFFF_FFFF;
					default: b.volume = $urandom_range(1, 5000);
				endcase
				send_bar(b, 1'b0, none);
			end
			wait_idle();
		end

		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
